// ===== rtl/sll_pkg.sv =====
// Package for the segment label lookup block: sizes, codes, words and states.
`default_nettype none

package sll_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int POS_BITS     = 32;
    localparam int IDX_BITS     = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int SYM_BITS     = 7;
    localparam int IO_POS_BITS  = 32;
    localparam int OP_BITS      = 2;
    localparam int STAT_BITS    = 3;
    localparam int DATA_BITS    = 40;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_SEEK   = 2'd3
    } t_opcode;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK          = 3'd0,
        STAT_NOT_FOUND   = 3'd1,
        STAT_EMPTY       = 3'd2,
        STAT_UNSEGMENTED = 3'd3,
        STAT_RANGE       = 3'd4,
        STAT_FULL        = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_E0,
        S_EC,
        S_LAST,
        S_BS,
        S_SYM,
        S_SCAN,
        S_PREV
    } t_state;

    typedef struct packed {
        t_opcode               opcode;
        logic [POS_BITS-1:0]   position;
        logic [SYM_BITS-1:0]   symbol;
    } t_item;

    typedef struct packed {
        logic [SYM_BITS-1:0]    symbol_out;
        logic [IO_POS_BITS-1:0] position_out;
        t_status                status;
    } t_result;

    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic [POS_BITS-1:0] seg_end;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/segment_label_lookup_top.sv =====
// Top level of the segment label lookup block: stream ports and result register.
//
// Usage: each word on the slave stream is one command (tuser = opcode: clear,
// append, lookup, seek) and yields exactly one result word on the master
// stream (tdata = symbol and position, tuser = status).
// Segments are appended in ascending end order; entry k covers samples from
// the end of entry k-1 (or 0) inclusive up to its own end exclusive.
// Steps, accept to result valid:
//   clear, append, and lookup/seek on an empty table: result in the next cycle.
//   lookup or seek: read entry 0 and the cursor entry; ends there if unsegmented.
//   lookup: then reads the last entry (ends there when out of range) and runs
//   binary search probes, at most ceil(log2(count)) (8 for a full table of 256
//   entries), one probe per single-port memory read. seek: ends if the cursor
//   segment still matches, else scans forward one entry per read, then its start.
// One command is in flight at a time; the next is taken once the core is idle
// again and the result register is free or its result is being taken.
// Reset empties the table by zeroing the fill count (no clearing pass) and
// parks the cursor at entry 0; entry contents are left as they are.
// A stalled receiver holds the result register; new commands are refused until
// it is free or being taken in the same cycle.
`default_nettype none

module segment_label_lookup_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [31:0] position, [38:32] symbol, [39] zero
    input  wire logic [39:0] i_s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [6:0] symbol_out, [38:7] position_out, [39] zero
    output logic [39:0]      o_m_axis_tdata,
    // [2:0] status
    output logic [2:0]       o_m_axis_tuser
);
    import sll_pkg::*;

    logic     w_idle;
    logic     w_done;
    logic     w_start;
    t_item    w_item;
    t_result  w_result;

    logic     r_out_valid, n_out_valid;
    t_result  r_out;

    // slot is free when empty or drained this cycle
    assign o_s_axis_tready = w_idle && (!r_out_valid || i_m_axis_tready);
    assign w_start         = i_s_axis_tvalid && o_s_axis_tready;

    assign w_item.opcode   = t_opcode'(i_s_axis_tuser);
    assign w_item.position = POS_BITS'(i_s_axis_tdata[IO_POS_BITS-1:0]);
    assign w_item.symbol   = i_s_axis_tdata[IO_POS_BITS +: SYM_BITS];

    sll_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_item   (w_item),
        .o_idle   (w_idle),
        .o_done   (w_done),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_done) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.position_out, r_out.symbol_out};
    assign o_m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

// ===== rtl/sll_core.sv =====
// Segment table engine: entry memory, binary search and forward seek sequencer.
`default_nettype none

module sll_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire sll_pkg::t_item  i_item,
    output logic                 o_idle,
    output logic                 o_done,
    output sll_pkg::t_result     o_result
);
    import sll_pkg::*;

    // entry memory, one port, registered read
    t_entry                mem [MAX_ENTRIES];
    t_entry                r_rdata;
    logic                  w_re;
    logic                  w_we;
    logic [IDX_BITS-1:0]   w_addr;
    t_entry                w_wdata;

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [IDX_BITS-1:0]   r_cursor, n_cursor;
    logic [IDX_BITS-1:0]   r_lo, n_lo;
    logic [IDX_BITS-1:0]   r_hi, n_hi;
    logic                  r_z0, n_z0;
    t_opcode               r_op, n_op;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [SYM_BITS-1:0]   r_sym, n_sym;

    logic [POS_BITS-1:0]   rd_end;
    logic [SYM_BITS-1:0]   rd_sym;
    logic [IDX_BITS-1:0]   c_mid_cur, c_lo, c_hi, c_mid;
    logic [IDX_BITS-1:0]   c_last;
    logic [CNT_BITS-1:0]   c_next;
    logic                  c_next_out;
    logic                  c_full;
    logic                  c_clamp;
    logic                  c_match_cur;
    logic                  c_unseg;

    assign rd_end      = r_rdata.seg_end;
    assign rd_sym      = r_rdata.symbol;
    assign c_last      = IDX_BITS'(r_count - CNT_BITS'(1));
    assign c_full      = (r_count >= CNT_BITS'(MAX_ENTRIES));
    assign c_clamp     = ({1'b0, r_cursor} >= r_count);
    assign c_next      = {1'b0, r_cursor} + CNT_BITS'(1);
    assign c_next_out  = (c_next >= r_count);
    assign c_match_cur = (rd_end > r_pos) && (rd_sym == r_sym);
    assign c_unseg     = r_z0 || (rd_end == '0);
    assign c_mid_cur   = r_lo + ((r_hi - r_lo) >> 1);

    // search window for the next probe
    always_comb begin
        if (r_state == S_LAST) begin
            c_lo = '0;
            c_hi = c_last;
        end else if (rd_end > r_pos) begin
            c_lo = r_lo;
            c_hi = c_mid_cur;
        end else begin
            c_lo = c_mid_cur + IDX_BITS'(1);
            c_hi = r_hi;
        end
    end
    assign c_mid = c_lo + ((c_hi - c_lo) >> 1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_z0  <= n_z0;
        r_op  <= n_op;
        r_pos <= n_pos;
        r_sym <= n_sym;
    end

    // next state and datapath registers
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_z0     = r_z0;
        n_op     = r_op;
        n_pos    = r_pos;
        n_sym    = r_sym;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_item.opcode;
                    n_pos = i_item.position;
                    n_sym = i_item.symbol;
                    unique case (i_item.opcode)
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        OP_APPEND: begin
                            if (!c_full) begin
                                n_count = r_count + CNT_BITS'(1);
                            end
                        end
                        OP_LOOKUP, OP_SEEK: begin
                            if (r_count != '0) begin
                                if (c_clamp) begin
                                    n_cursor = '0;
                                end
                                n_state = S_E0;
                            end
                        end
                    endcase
                end
            end
            S_E0: begin
                n_z0    = (rd_end == '0);
                n_state = S_EC;
            end
            S_EC: begin
                if (c_unseg) begin
                    n_state = S_IDLE;
                end else if (r_op == OP_LOOKUP) begin
                    n_state = S_LAST;
                end else if (c_match_cur) begin
                    n_state = S_IDLE;
                end else if (c_next_out) begin
                    n_cursor = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cursor = IDX_BITS'(c_next);
                    n_state  = S_SCAN;
                end
            end
            S_LAST, S_BS: begin
                n_lo = c_lo;
                n_hi = c_hi;
                if (r_state == S_LAST && r_pos >= rd_end) begin
                    n_state = S_IDLE;
                end else if (c_lo < c_hi) begin
                    n_state = S_BS;
                end else begin
                    n_state = S_SYM;
                end
            end
            S_SYM: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (rd_sym == r_sym) begin
                    n_state = S_PREV;
                end else if (c_next_out) begin
                    n_cursor = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cursor = IDX_BITS'(c_next);
                end
            end
            S_PREV: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory access and result
    always_comb begin
        w_re     = 1'b0;
        w_we     = 1'b0;
        w_addr   = '0;
        w_wdata  = '{symbol: i_item.symbol, seg_end: i_item.position};
        o_idle   = (r_state == S_IDLE);
        o_done   = 1'b0;
        o_result = '{symbol_out: '0, position_out: '0, status: STAT_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_item.opcode)
                        OP_CLEAR: begin
                            o_done = 1'b1;
                        end
                        OP_APPEND: begin
                            o_done = 1'b1;
                            if (c_full) begin
                                o_result.status = STAT_FULL;
                            end else begin
                                w_we   = 1'b1;
                                w_addr = IDX_BITS'(r_count);
                            end
                        end
                        OP_LOOKUP, OP_SEEK: begin
                            if (r_count == '0) begin
                                o_done          = 1'b1;
                                o_result.status = STAT_EMPTY;
                            end else begin
                                w_re   = 1'b1;
                                w_addr = '0;
                            end
                        end
                    endcase
                end
            end
            S_E0: begin
                w_re   = 1'b1;
                w_addr = r_cursor;
            end
            S_EC: begin
                if (c_unseg) begin
                    o_done          = 1'b1;
                    o_result.status = STAT_UNSEGMENTED;
                end else if (r_op == OP_LOOKUP) begin
                    w_re   = 1'b1;
                    w_addr = c_last;
                end else if (c_match_cur) begin
                    o_done                = 1'b1;
                    o_result.position_out = IO_POS_BITS'(r_pos);
                end else if (c_next_out) begin
                    o_done          = 1'b1;
                    o_result.status = STAT_NOT_FOUND;
                end else begin
                    w_re   = 1'b1;
                    w_addr = IDX_BITS'(c_next);
                end
            end
            S_LAST, S_BS: begin
                if (r_state == S_LAST && r_pos >= rd_end) begin
                    o_done          = 1'b1;
                    o_result.status = STAT_RANGE;
                end else begin
                    w_re   = 1'b1;
                    w_addr = (c_lo < c_hi) ? c_mid : c_lo;
                end
            end
            S_SYM: begin
                o_done              = 1'b1;
                o_result.symbol_out = rd_sym;
            end
            S_SCAN: begin
                if (rd_sym == r_sym) begin
                    w_re   = 1'b1;
                    w_addr = r_cursor - IDX_BITS'(1);
                end else if (c_next_out) begin
                    o_done          = 1'b1;
                    o_result.status = STAT_NOT_FOUND;
                end else begin
                    w_re   = 1'b1;
                    w_addr = IDX_BITS'(c_next);
                end
            end
            S_PREV: begin
                o_done                = 1'b1;
                o_result.position_out = IO_POS_BITS'(rd_end);
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sll_checker.sv =====
// Port-level checker for the segment label lookup block, bound to the top level.
`default_nettype none

module sll_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [39:0] i_s_axis_tdata,
    input wire logic [1:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [2:0]  o_m_axis_tuser
);
    import sll_pkg::*;

    logic w_in_word;
    assign w_in_word = i_s_axis_tvalid && o_s_axis_tready;

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result word changed while stalled");

    // clear answers ok in the next cycle
    a_clear_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_word && (i_s_axis_tuser == OP_CLEAR) |=>
            o_m_axis_tvalid && (o_m_axis_tuser == STAT_OK))
        else $error("clear not answered next cycle with ok");

    // failed commands carry no symbol or position
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != STAT_OK) |->
            (o_m_axis_tdata == '0))
        else $error("nonzero payload on failing status");

    // one command in flight: right after a word is taken, ready stays low unless a result is valid
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_word |=> !o_s_axis_tready || o_m_axis_tvalid)
        else $error("command accepted back to back without result");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind segment_label_lookup_top sll_checker u_sll_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
